>>> hdl/fdb_pkg.sv
// fdb_pkg: shared types, constants and coefficient generation for the FIR decimator.
// Depends on nothing; used by fdb_cell, fdb_mac and fir_decimator_by_three_core.
package fdb_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int ACC_BITS        = 40;
  localparam int TAPS_DEF        = 47;
  localparam int RATIO_DEF       = 3;
  localparam int SAMPLE_RATE_DEF = 48000;
  localparam int COEF_BITS_DEF   = 18;

  localparam longint CUTOFF_HZ   = 7000;
  localparam longint ONE_Q30     = 64'd1 << 30;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 1686629713;
  localparam longint SAMPLE_MAX  = 32767;
  localparam longint SAMPLE_MIN  = -32768;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } fdb_state_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
  } fdb_mac_ctl_t;

  // restoring shift-subtract division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // signed division truncating toward zero
  function automatic longint sdiv64(input longint n, input longint d);
    logic [63:0] mn;
    logic [63:0] md;
    logic [63:0] q;
    mn = (n < 0) ? 64'(-n) : 64'(n);
    md = (d < 0) ? 64'(-d) : 64'(d);
    q  = udiv64(mn, md);
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // sine over a quarter turn, Q30 in and out
  function automatic logic [63:0] sin_quarter(input logic [63:0] r);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] div;
    a    = (r * 64'(HALF_PI_Q30)) >> 30;
    a2   = (a * a) >> 30;
    term = 64'(ONE_Q30);
    for (int n = 7; n >= 1; n--) begin
      div  = 64'(2 * n) * 64'(2 * n + 1);
      term = 64'(ONE_Q30) - udiv64((a2 * term) >> 30, div);
    end
    return (a * term) >> 30;
  endfunction

  // sine of a Q32 turn fraction, Q30
  function automatic longint sin_turn(input logic [31:0] p);
    logic [63:0] r;
    r = {34'd0, p[29:0]};
    case (p[31:30])
      2'd0:    return longint'(sin_quarter(r));
      2'd1:    return longint'(sin_quarter(64'(ONE_Q30) - r));
      2'd2:    return -longint'(sin_quarter(r));
      default: return -longint'(sin_quarter(64'(ONE_Q30) - r));
    endcase
  endfunction

  // unnormalized windowed-sinc tap
  function automatic longint coef_v(input longint taps, input longint rate, input longint k);
    longint      d;
    longint      x2;
    longint      sinc;
    longint      c;
    longint      hann;
    logic [63:0] t;
    logic [31:0] p;
    d  = 2 * k - (taps - 1);
    x2 = (d < 0) ? -d : d;
    if (x2 == 0) begin
      sinc = longint'(udiv64(64'(CUTOFF_HZ) << 31, 64'(rate)));
    end else begin
      t    = udiv64(64'(CUTOFF_HZ * x2) << 32, 64'(2 * rate));
      p    = t[31:0];
      sinc = sdiv64(sin_turn(p) * (longint'(1) <<< 31), PI_Q30 * x2);
    end
    t    = udiv64(64'(k) << 32, 64'(taps - 1));
    p    = t[31:0];
    c    = sin_turn(p + 32'h4000_0000);
    hann = sdiv64(ONE_Q30 - c, 2);
    return sdiv64(sinc * hann, ONE_Q30);
  endfunction

  function automatic longint coef_sum(input longint taps, input longint rate);
    longint s;
    s = 0;
    for (longint k = 0; k < taps; k++) begin
      s = s + coef_v(taps, rate, k);
    end
    return (s <= 0) ? 64'sd1 : s;
  endfunction

  // normalized, rounded and saturated tap
  function automatic longint coef_q(input longint taps, input longint rate,
                                    input longint coef_bits, input longint k,
                                    input longint s);
    longint v;
    longint mag;
    longint q;
    longint maxc;
    longint minc;
    v    = coef_v(taps, rate, k);
    mag  = (v < 0) ? -v : v;
    q    = longint'(udiv64(64'((mag <<< (coef_bits - 1)) + (s >>> 1)), 64'(s)));
    q    = (v < 0) ? -q : q;
    maxc = (longint'(1) <<< (coef_bits - 1)) - 1;
    minc = -(longint'(1) <<< (coef_bits - 1));
    if (q > maxc) q = maxc;
    if (q < minc) q = minc;
    return q;
  endfunction

endpackage

>>> hdl/fdb_cell.sv
// fdb_cell: one delay-line cell holding a single sample.
// Depends on fdb_pkg.
module fdb_cell (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 shift_en,
  input  logic signed [fdb_pkg::SAMPLE_W-1:0]  d_i,
  output logic signed [fdb_pkg::SAMPLE_W-1:0]  q_o
);
  import fdb_pkg::*;

  logic signed [SAMPLE_W-1:0] q_r;
  logic signed [SAMPLE_W-1:0] q_nxt;

  always_comb begin
    q_nxt = shift_en ? d_i : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

>>> hdl/fdb_mac.sv
// fdb_mac: coefficient ROM, registered multiplier, accumulator and Q15 round/saturate.
// Depends on fdb_pkg.
module fdb_mac #(
  parameter int TAPS        = fdb_pkg::TAPS_DEF,
  parameter int SAMPLE_RATE = fdb_pkg::SAMPLE_RATE_DEF,
  parameter int COEF_BITS   = fdb_pkg::COEF_BITS_DEF,
  parameter int IDX_W       = $clog2(TAPS)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fdb_pkg::fdb_mac_ctl_t                ctl,
  input  logic [IDX_W-1:0]                     idx,
  input  logic signed [fdb_pkg::SAMPLE_W-1:0]  sample_i,
  output logic signed [fdb_pkg::SAMPLE_W-1:0]  y_o
);
  import fdb_pkg::*;

  localparam int     PROD_W  = SAMPLE_W + COEF_BITS;
  localparam int     ACC_W   = PROD_W + $clog2(TAPS);
  localparam int     SAT_W   = (ACC_W > ACC_BITS) ? ACC_W : ACC_BITS;
  localparam int     FRAC    = COEF_BITS - 1;
  localparam longint SUM_H   = coef_sum(TAPS, SAMPLE_RATE);
  localparam logic signed [SAT_W-1:0] ACC_MAX =
    SAT_W'((longint'(1) <<< (ACC_BITS - 1)) - 1);
  localparam logic signed [SAT_W-1:0] ACC_MIN =
    SAT_W'(-(longint'(1) <<< (ACC_BITS - 1)));
  localparam logic signed [ACC_BITS:0] RND_C = (ACC_BITS + 1)'(longint'(1) <<< (FRAC - 1));
  localparam logic signed [ACC_BITS:0] Y_MAX = (ACC_BITS + 1)'(SAMPLE_MAX);
  localparam logic signed [ACC_BITS:0] Y_MIN = (ACC_BITS + 1)'(SAMPLE_MIN);

  logic signed [COEF_BITS-1:0] rom [TAPS];

  for (genvar g = 0; g < TAPS; g++) begin : g_rom
    localparam longint HQ = coef_q(TAPS, SAMPLE_RATE, COEF_BITS, g, SUM_H);
    assign rom[g] = HQ[COEF_BITS-1:0];
  end

  logic signed [PROD_W-1:0]   product_r;
  logic signed [PROD_W-1:0]   product_nxt;
  logic                       prod_vld_r;
  logic                       prod_vld_nxt;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    acc_nxt;
  logic signed [SAT_W-1:0]    acc_ext;
  logic signed [ACC_BITS-1:0] acc_sat;
  logic signed [ACC_BITS:0]   acc_rnd;
  logic signed [ACC_BITS:0]   acc_shr;

  always_comb begin
    product_nxt  = sample_i * rom[idx];
    prod_vld_nxt = ctl.mul_en && !ctl.clear;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (prod_vld_r) begin
      acc_nxt = acc_r + ACC_W'(product_r);
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      acc_r      <= '0;
    end else begin
      prod_vld_r <= prod_vld_nxt;
      acc_r      <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    product_r <= product_nxt;
  end

  // clamp to 40 bits, round half up to Q15, clamp to 16 bits
  always_comb begin
    acc_ext = SAT_W'(acc_r);
    if (acc_ext > ACC_MAX) begin
      acc_sat = ACC_MAX[ACC_BITS-1:0];
    end else if (acc_ext < ACC_MIN) begin
      acc_sat = ACC_MIN[ACC_BITS-1:0];
    end else begin
      acc_sat = acc_ext[ACC_BITS-1:0];
    end
    acc_rnd = (ACC_BITS + 1)'(acc_sat) + RND_C;
    acc_shr = acc_rnd >>> FRAC;
    if (acc_shr > Y_MAX) begin
      y_o = Y_MAX[SAMPLE_W-1:0];
    end else if (acc_shr < Y_MIN) begin
      y_o = Y_MIN[SAMPLE_W-1:0];
    end else begin
      y_o = acc_shr[SAMPLE_W-1:0];
    end
  end

endmodule

>>> hdl/fir_decimator_by_three_core.sv
// fir_decimator_by_three_core: top level, rotating chain of sample cells feeding one MAC.
// Depends on fdb_pkg, fdb_cell, fdb_mac.
//
// Usage:
//   Input channel in_valid/in_stall/in_sample carries one signed Q15 sample per request.
//   Output channel out_valid/out_stall/out_filtered_sample carries one low-passed,
//   decimated sample for every RATIO input samples (the first, fourth, ... after reset).
//   A sample that yields no output is taken while the block stays idle. A sample that yields an
//   output starts a pass in which the TAPS-cell chain rotates once through the single
//   multiplier, through the run, drain and finish states, with in_stall high until the
//   result is loaded, so no further sample is taken before the pass ends.
//   The rotation through the shared multiply-accumulate sets the length of the pass.
//   The result sits in an output register; further samples are taken while it waits.
//   If the receiver still stalls when the next result is ready, the block holds in
//   its final state with in_stall high until the register frees.
//   Synchronous reset clears the delay line to zero and the decimation phase to zero;
//   no results are pending after reset.
module fir_decimator_by_three_core #(
  parameter int TAPS        = fdb_pkg::TAPS_DEF,
  parameter int RATIO       = fdb_pkg::RATIO_DEF,
  parameter int SAMPLE_RATE = fdb_pkg::SAMPLE_RATE_DEF,
  parameter int COEF_BITS   = fdb_pkg::COEF_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [fdb_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [fdb_pkg::SAMPLE_W-1:0]  out_filtered_sample
);
  import fdb_pkg::*;

  localparam int               IDX_W    = $clog2(TAPS);
  localparam int               PH_W     = $clog2(RATIO);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TAPS - 1);
  localparam logic [PH_W-1:0]  PH_LAST  = PH_W'(RATIO - 1);

  fdb_state_t                 state_r;
  fdb_state_t                 state_nxt;
  logic [IDX_W-1:0]           idx_r;
  logic [IDX_W-1:0]           idx_nxt;
  logic [PH_W-1:0]            phase_r;
  logic [PH_W-1:0]            phase_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_data_r;
  logic signed [SAMPLE_W-1:0] out_data_nxt;

  logic                       in_accept;
  logic                       load_out;
  logic                       shift_en;
  fdb_mac_ctl_t               mac_ctl;
  logic signed [SAMPLE_W-1:0] chain_q [TAPS];
  logic signed [SAMPLE_W-1:0] head_d;
  logic signed [SAMPLE_W-1:0] mac_y;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // new sample enters at the head; during a pass the tail wraps back to the head
  assign head_d   = (state_r == ST_RUN) ? chain_q[TAPS-1] : in_sample;
  assign shift_en = in_accept || (state_r == ST_RUN);

  for (genvar g = 0; g < TAPS; g++) begin : g_chain
    if (g == 0) begin : g_head
      fdb_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d_i      (head_d),
        .q_o      (chain_q[g])
      );
    end else begin : g_body
      fdb_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d_i      (chain_q[g-1]),
        .q_o      (chain_q[g])
      );
    end
  end

  fdb_mac #(
    .TAPS        (TAPS),
    .SAMPLE_RATE (SAMPLE_RATE),
    .COEF_BITS   (COEF_BITS),
    .IDX_W       (IDX_W)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mac_ctl),
    .idx      (idx_r),
    .sample_i (chain_q[TAPS-1]),
    .y_o      (mac_y)
  );

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    phase_nxt      = phase_r;
    load_out       = 1'b0;
    mac_ctl.clear  = 1'b0;
    mac_ctl.mul_en = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          phase_nxt = (phase_r == PH_LAST) ? '0 : phase_r + 1'b1;
          if (phase_r == '0) begin
            state_nxt     = ST_RUN;
            idx_nxt       = IDX_LAST;
            mac_ctl.clear = 1'b1;
          end
        end
      end
      ST_RUN: begin
        mac_ctl.mul_en = 1'b1;
        if (idx_r == '0) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = mac_y;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
      out_data_nxt  = out_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_filtered_sample = out_data_r;

`ifndef SYNTH
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_FINISH))
    else $error("result appeared outside finish state");

  a_idx_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && $past(state_r == ST_RUN) |-> idx_r == $past(idx_r) - 1'b1)
    else $error("tap index did not step during rotation");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_LAST)
    else $error("decimation phase out of range");

  a_skip_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (phase_r != '0) |=> state_r == ST_IDLE)
    else $error("non-output sample started a pass");

  a_pass_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (phase_r == '0) |=> (state_r == ST_RUN) && (idx_r == IDX_LAST))
    else $error("output sample did not start a full pass");
`endif

endmodule
